### hdl/fism_pkg.sv
// Frame interval statistics meter: shared types and constants.
// Used by fism_div and frame_interval_statistics_meter; no dependencies.
package fism_pkg;

  localparam int TIME_BITS_DEF = 48;
  localparam int TS_W          = 48;
  localparam int BUDGET_W      = 30;
  localparam int COUNT_W       = 32;
  localparam int HR_W          = 17;
  localparam int HR_FRAC       = 16;
  localparam int DIVISOR_W     = 32;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 30'd16666667;
  localparam logic [HR_W-1:0]     HR_ONE       = 17'h10000;

  localparam logic [1:0] ACT_BEGIN      = 2'd0;
  localparam logic [1:0] ACT_RENDER_END = 2'd1;
  localparam logic [1:0] ACT_CLEAR      = 2'd2;

  typedef struct packed {
    logic [1:0]      action;
    logic [TS_W-1:0] timestamp_ns;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] frame_count;
    logic [COUNT_W-1:0] late_count;
    logic [TS_W-1:0]    mean_interval_ns;
    logic [TS_W-1:0]    worst_interval_ns;
    logic [TS_W-1:0]    mean_render_ns;
    logic [TS_W-1:0]    worst_render_ns;
    logic [HR_W-1:0]    render_headroom;
    logic [HR_W-1:0]    frame_headroom;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hdl/fism_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on fism_pkg for the status struct.
module fism_div #(
  parameter int DW = 48,
  parameter int VW = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DW-1:0]       dividend,
  input  logic [VW-1:0]       divisor,
  output fism_pkg::div_stat_t stat,
  output logic [DW-1:0]       quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [VW-1:0]    rem_r;
  logic [VW-1:0]    dvs_r;
  logic [DW-1:0]    quo_r;
  logic [VW:0]      shifted;
  logic [VW:0]      trial;
  logic             fits;

  assign shifted = {rem_r, quo_r[DW-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? trial[VW-1:0] : shifted[VW-1:0];
        quo_r <= {quo_r[DW-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

### hdl/frame_interval_statistics_meter.sv
// Frame interval statistics meter: event sequencer, statistics registers.
// Depends on fism_pkg and fism_div (shared divider for means and headrooms).
//
//  channel | ports                         | handshake
//  --------+-------------------------------+------------------------------
//  input   | in_valid, in_stall, in_data   | transfer on valid && !stall
//  result  | out_valid, out_stall, out_data| transfer on valid && !stall
//  config  | cfg_valid, cfg_ready, cfg_data| write on valid && ready
//
// One event passes from transfer to result through four serial divisions on the one
// divider (two means, two headrooms); the divider width is DW = max(TIME_BITS, 46).
// A division with a zero divisor or a fixed answer is skipped.
// in_stall is high from the transfer until the result is loaded.
// The result register frees the sequencer while a result waits on out_stall.
// Reset is synchronous; budget returns to 16666667 ns.
module frame_interval_statistics_meter #(
  parameter int TIME_BITS = fism_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  fism_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fism_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fism_pkg::BUDGET_W-1:0]     cfg_data
);

  localparam int BW    = fism_pkg::BUDGET_W;
  localparam int NUM_W = BW + fism_pkg::HR_FRAC;
  localparam int DW    = (TIME_BITS > NUM_W) ? TIME_BITS : NUM_W;
  localparam int VW    = fism_pkg::DIVISOR_W;
  localparam int CW    = fism_pkg::COUNT_W;
  localparam int HW    = fism_pkg::HR_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_ACC, S_MI_GO, S_MI_WAIT, S_MR_GO, S_MR_WAIT,
    S_HC_GO, S_HC_WAIT, S_HF_GO, S_HF_WAIT, S_OUT
  } state_t;

  state_t                  state_r;
  logic [BW-1:0]           budget_r;
  logic [BW:0]             thr_r;
  logic [1:0]              action_r;
  logic [TIME_BITS-1:0]    now_r;
  logic [TIME_BITS-1:0]    diff_r;
  logic [TIME_BITS-1:0]    last_r;
  logic                    have_last_r;
  logic [TIME_BITS-1:0]    rstart_r;
  logic                    have_rs_r;
  logic [TIME_BITS-1:0]    isum_r;
  logic [TIME_BITS-1:0]    iworst_r;
  logic [TIME_BITS-1:0]    rsum_r;
  logic [TIME_BITS-1:0]    rworst_r;
  logic [CW-1:0]           frames_r;
  logic [CW-1:0]           late_r;
  logic [TIME_BITS-1:0]    mi_r;
  logic [TIME_BITS-1:0]    mr_r;
  logic [HW-1:0]           hc_r;
  logic [HW-1:0]           hf_r;
  logic                    div_start_r;
  logic [DW-1:0]           div_a_r;
  logic [VW-1:0]           div_b_r;
  logic                    out_valid_r;
  fism_pkg::out_item_t     out_data_r;

  fism_pkg::div_stat_t     div_st;
  logic [DW-1:0]           div_q;
  logic [TIME_BITS:0]      isum_add;
  logic [TIME_BITS:0]      rsum_add;
  logic [TIME_BITS-1:0]    isum_sat;
  logic [TIME_BITS-1:0]    rsum_sat;
  logic                    in_fire;

  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = state_r != S_IDLE;
  assign cfg_ready = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign isum_add = {1'b0, isum_r} + {1'b0, diff_r};
  assign rsum_add = {1'b0, rsum_r} + {1'b0, diff_r};
  assign isum_sat = isum_add[TIME_BITS] ? '1 : isum_add[TIME_BITS-1:0];
  assign rsum_sat = rsum_add[TIME_BITS] ? '1 : rsum_add[TIME_BITS-1:0];

  fism_div #(
    .DW(DW),
    .VW(VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .stat     (div_st),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      budget_r    <= fism_pkg::BUDGET_RESET;
      last_r      <= '0;
      have_last_r <= 1'b0;
      rstart_r    <= '0;
      have_rs_r   <= 1'b0;
      isum_r      <= '0;
      iworst_r    <= '0;
      rsum_r      <= '0;
      rworst_r    <= '0;
      frames_r    <= '0;
      late_r      <= '0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        budget_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            action_r <= in_data.action;
            now_r    <= TIME_BITS'(in_data.timestamp_ns);
            state_r  <= S_DIFF;
          end
        end
        S_DIFF: begin
          diff_r  <= now_r - ((action_r == fism_pkg::ACT_BEGIN) ? last_r : rstart_r);
          thr_r   <= {1'b0, budget_r} + (BW + 1)'(budget_r >> 1);
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (action_r == fism_pkg::ACT_BEGIN) begin
            if (have_last_r) begin
              isum_r <= isum_sat;
              if (diff_r > iworst_r) iworst_r <= diff_r;
              if (diff_r > TIME_BITS'(thr_r) && late_r != '1) late_r <= late_r + 1'b1;
              if (frames_r != '1) frames_r <= frames_r + 1'b1;
            end
            last_r      <= now_r;
            have_last_r <= 1'b1;
            rstart_r    <= now_r;
            have_rs_r   <= 1'b1;
          end else if (action_r == fism_pkg::ACT_RENDER_END) begin
            if (have_rs_r) begin
              rsum_r <= rsum_sat;
              if (diff_r > rworst_r) rworst_r <= diff_r;
            end
          end else if (action_r == fism_pkg::ACT_CLEAR) begin
            isum_r      <= '0;
            iworst_r    <= '0;
            rsum_r      <= '0;
            rworst_r    <= '0;
            frames_r    <= '0;
            late_r      <= '0;
            have_last_r <= 1'b0;
            last_r      <= '0;
          end
          state_r <= S_MI_GO;
        end
        S_MI_GO: begin
          if (frames_r == '0) begin
            mi_r    <= '0;
            state_r <= S_MR_GO;
          end else begin
            div_a_r     <= DW'(isum_r);
            div_b_r     <= VW'(frames_r);
            div_start_r <= 1'b1;
            state_r     <= S_MI_WAIT;
          end
        end
        S_MI_WAIT: begin
          div_start_r <= 1'b0;
          if (div_st.done) begin
            mi_r    <= TIME_BITS'(div_q);
            state_r <= S_MR_GO;
          end
        end
        S_MR_GO: begin
          if (frames_r == '0) begin
            mr_r    <= '0;
            state_r <= S_HC_GO;
          end else begin
            div_a_r     <= DW'(rsum_r);
            div_b_r     <= VW'(frames_r);
            div_start_r <= 1'b1;
            state_r     <= S_MR_WAIT;
          end
        end
        S_MR_WAIT: begin
          div_start_r <= 1'b0;
          if (div_st.done) begin
            mr_r    <= TIME_BITS'(div_q);
            state_r <= S_HC_GO;
          end
        end
        S_HC_GO: begin
          if (mr_r == '0) begin
            hc_r    <= fism_pkg::HR_ONE;
            state_r <= S_HF_GO;
          end else if (budget_r == '0 || mr_r >= TIME_BITS'(budget_r)) begin
            hc_r    <= '0;
            state_r <= S_HF_GO;
          end else begin
            div_a_r     <= DW'({budget_r - mr_r[BW-1:0], {fism_pkg::HR_FRAC{1'b0}}});
            div_b_r     <= VW'(budget_r);
            div_start_r <= 1'b1;
            state_r     <= S_HC_WAIT;
          end
        end
        S_HC_WAIT: begin
          div_start_r <= 1'b0;
          if (div_st.done) begin
            hc_r    <= HW'(div_q);
            state_r <= S_HF_GO;
          end
        end
        S_HF_GO: begin
          if (mi_r == '0) begin
            hf_r    <= fism_pkg::HR_ONE;
            state_r <= S_OUT;
          end else if (budget_r == '0 || mi_r >= TIME_BITS'(budget_r)) begin
            hf_r    <= '0;
            state_r <= S_OUT;
          end else begin
            div_a_r     <= DW'({budget_r - mi_r[BW-1:0], {fism_pkg::HR_FRAC{1'b0}}});
            div_b_r     <= VW'(budget_r);
            div_start_r <= 1'b1;
            state_r     <= S_HF_WAIT;
          end
        end
        S_HF_WAIT: begin
          div_start_r <= 1'b0;
          if (div_st.done) begin
            hf_r    <= HW'(div_q);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r                  <= 1'b1;
            out_data_r.frame_count       <= frames_r;
            out_data_r.late_count        <= late_r;
            out_data_r.mean_interval_ns  <= fism_pkg::TS_W'(mi_r);
            out_data_r.worst_interval_ns <= fism_pkg::TS_W'(iworst_r);
            out_data_r.mean_render_ns    <= fism_pkg::TS_W'(mr_r);
            out_data_r.worst_render_ns   <= fism_pkg::TS_W'(rworst_r);
            out_data_r.render_headroom   <= hc_r;
            out_data_r.frame_headroom    <= hf_r;
            state_r                      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_late_le_frames: assert property (@(posedge clk) disable iff (!rst_n)
    late_r <= frames_r)
    else $error("late count above frame count");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> !div_st.busy)
    else $error("divider started while busy");

  a_hr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.render_headroom <= fism_pkg::HR_ONE &&
                     out_data_r.frame_headroom <= fism_pkg::HR_ONE))
    else $error("headroom above one");

endmodule
